[design/assert_macros.svh]
// Assertion macros shared by the LED pattern generator RTL.
// Depends on nothing; included by the modules that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LPG_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("same-cycle implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LPG_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("next-cycle implication check failed");

`endif

[design/lpg_pkg.sv]
// Shared types, codes, constants and the PWM curve of the LED pattern generator.
// Depends on nothing; imported by every module of the block.
package lpg_pkg;

    // Mode codes.
    localparam logic [2:0] MODE_OFF     = 3'd0;
    localparam logic [2:0] MODE_ON      = 3'd1;
    localparam logic [2:0] MODE_SLOW    = 3'd2;
    localparam logic [2:0] MODE_FAST    = 3'd3;
    localparam logic [2:0] MODE_BREATHE = 3'd4;

    // Configuration register indexes.
    localparam logic [2:0] CFG_MODE      = 3'd0;
    localparam logic [2:0] CFG_SLOW_ON   = 3'd1;
    localparam logic [2:0] CFG_SLOW_OFF  = 3'd2;
    localparam logic [2:0] CFG_FAST_HALF = 3'd3;
    localparam logic [2:0] CFG_INHALE    = 3'd4;
    localparam logic [2:0] CFG_EXHALE    = 3'd5;
    localparam logic [2:0] CFG_PAUSE     = 3'd6;

    // Reset values of the timing registers.
    localparam logic [15:0] RST_SLOW_ON   = 16'd50;
    localparam logic [15:0] RST_SLOW_OFF  = 16'd2000;
    localparam logic [15:0] RST_FAST_HALF = 16'd100;
    localparam logic [15:0] RST_INHALE    = 16'd2000;
    localparam logic [15:0] RST_EXHALE    = 16'd2500;
    localparam logic [15:0] RST_PAUSE     = 16'd1200;

    // Brightness and PWM constants.
    localparam logic [6:0] PCT_FULL     = 7'd100;
    localparam logic [6:0] BREATH_FLOOR = 7'd10;
    localparam logic [9:0] PWM_TOP      = 10'd1023;

    // Ratio divider geometry: the quotient never exceeds 100.
    localparam int QUO_W = 7;
    localparam int REM_W = 24;
    localparam int DEN_W = 16;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic eval;
        logic finish;
    } lpg_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_busy;
    } lpg_sts_t;

    // floor(2^(p/10)) - 1 for p = 0..100.
    localparam logic [9:0] PWM_CURVE [0:100] = '{
        10'd0,   10'd0,   10'd0,   10'd0,   10'd0,   10'd0,   10'd0,   10'd0,
        10'd0,   10'd0,   10'd1,   10'd1,   10'd1,   10'd1,   10'd1,   10'd1,
        10'd2,   10'd2,   10'd2,   10'd2,   10'd3,   10'd3,   10'd3,   10'd3,
        10'd4,   10'd4,   10'd5,   10'd5,   10'd5,   10'd6,   10'd7,   10'd7,
        10'd8,   10'd8,   10'd9,   10'd10,  10'd11,  10'd11,  10'd12,  10'd13,
        10'd15,  10'd16,  10'd17,  10'd18,  10'd20,  10'd21,  10'd23,  10'd24,
        10'd26,  10'd28,  10'd31,  10'd33,  10'd35,  10'd38,  10'd41,  10'd44,
        10'd47,  10'd50,  10'd54,  10'd58,  10'd63,  10'd67,  10'd72,  10'd77,
        10'd83,  10'd89,  10'd96,  10'd102, 10'd110, 10'd118, 10'd127, 10'd136,
        10'd146, 10'd156, 10'd167, 10'd180, 10'd193, 10'd206, 10'd221, 10'd237,
        10'd255, 10'd273, 10'd293, 10'd314, 10'd336, 10'd361, 10'd387, 10'd414,
        10'd444, 10'd476, 10'd511, 10'd547, 10'd587, 10'd629, 10'd674, 10'd723,
        10'd775, 10'd830, 10'd890, 10'd954, 10'd1023
    };

    // Curve lookup; percents above full scale never occur and read as zero.
    function automatic logic [9:0] pwm_curve(input logic [6:0] pct);
        logic [9:0] val;
        if (pct > PCT_FULL) begin
            val = 10'd0;
        end else begin
            val = PWM_CURVE[pct];
        end
        return val;
    endfunction

endpackage

[design/lpg_divider.sv]
// Restoring divider for the breathing ramp: round(100*num/den), one quotient bit a cycle.
// Depends on lpg_pkg.
module lpg_divider (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [lpg_pkg::DEN_W-1:0] num,
    input  logic [lpg_pkg::DEN_W-1:0] den,
    output logic                      busy,
    output logic [lpg_pkg::QUO_W-1:0] quotient
);
    import lpg_pkg::*;

    localparam logic [2:0] LAST_STEP = 3'(QUO_W - 1);

    logic [REM_W-1:0] rem_reg;
    logic [REM_W-1:0] rem_next;
    logic [DEN_W:0]   dsor_reg;
    logic [QUO_W-1:0] quo_reg;
    logic [QUO_W-1:0] quo_next;
    logic [2:0]       step_reg;
    logic             busy_reg;
    logic [REM_W-1:0] num_ext;
    logic [REM_W-1:0] dividend;
    logic [REM_W-1:0] trial;
    logic             fits;

    // Dividend is 200*num + den, divisor is 2*den; the quotient stays below 128.
    assign num_ext  = REM_W'(num);
    assign dividend = (num_ext << 7) + (num_ext << 6) + (num_ext << 3) + REM_W'(den);

    // Compare against the divisor aligned to the current quotient bit.
    assign trial = REM_W'(dsor_reg) << step_reg;
    assign fits  = (rem_reg >= trial);

    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        if (fits) begin
            rem_next = rem_reg - trial;
            quo_next[step_reg] = 1'b1;
        end
    end

    // Step control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            step_reg <= 3'd0;
        end else if (start) begin
            busy_reg <= 1'b1;
            step_reg <= LAST_STEP;
        end else if (busy_reg) begin
            if (step_reg == 3'd0) begin
                busy_reg <= 1'b0;
            end else begin
                step_reg <= step_reg - 3'd1;
            end
        end
    end

    // Remainder and quotient.
    always_ff @(posedge clk)
    begin
        if (start) begin
            rem_reg  <= dividend;
            dsor_reg <= {den, 1'b0};
            quo_reg  <= '0;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

[design/lpg_datapath.sv]
// Datapath of the LED pattern generator: configuration, brightness state, pattern
// decisions, ratio divider and output payload. Depends on lpg_pkg and lpg_divider.
`include "assert_macros.svh"
module lpg_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [15:0]       cfg_data,
    input  logic [31:0]       now_ms,
    input  lpg_pkg::lpg_cmd_t cmd,
    output lpg_pkg::lpg_sts_t sts,
    output logic [9:0]        pwm_level,
    output logic [6:0]        brightness_pct
);
    import lpg_pkg::*;

    // Configuration registers.
    logic [2:0]  mode_reg;
    logic [15:0] slow_on_reg;
    logic [15:0] slow_off_reg;
    logic [15:0] fast_half_reg;
    logic [15:0] inhale_reg;
    logic [15:0] exhale_reg;
    logic [15:0] pause_reg;

    // Pattern state.
    logic [6:0]  brightness_reg;
    logic [31:0] last_change_reg;

    // Per-transaction working registers.
    logic [31:0] now_reg;
    logic [31:0] elapsed_reg;
    logic [16:0] ramp_sum_reg;
    logic [17:0] cycle_reg;
    logic [6:0]  br_pend_reg;
    logic        div_used_reg;
    logic [9:0]  pwm_reg;
    logic [6:0]  pct_reg;

    // Evaluation results.
    logic [6:0]  br_eval;
    logic        touch;
    logic        do_div;
    logic [15:0] div_num;
    logic [15:0] div_den;
    logic        restart;
    logic [31:0] breath_e;
    logic        below_inhale;
    logic        below_ramps;
    logic [16:0] exhale_left;

    // Finish results.
    logic [6:0]  br_pre;
    logic [6:0]  br_floor;
    logic [6:0]  br_fin;

    logic        div_busy;
    logic [6:0]  div_quo;

    // Configuration writes; bits above a register's width are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg      <= MODE_OFF;
            slow_on_reg   <= RST_SLOW_ON;
            slow_off_reg  <= RST_SLOW_OFF;
            fast_half_reg <= RST_FAST_HALF;
            inhale_reg    <= RST_INHALE;
            exhale_reg    <= RST_EXHALE;
            pause_reg     <= RST_PAUSE;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_MODE:      mode_reg      <= cfg_data[2:0];
                CFG_SLOW_ON:   slow_on_reg   <= cfg_data;
                CFG_SLOW_OFF:  slow_off_reg  <= cfg_data;
                CFG_FAST_HALF: fast_half_reg <= cfg_data;
                CFG_INHALE:    inhale_reg    <= cfg_data;
                CFG_EXHALE:    exhale_reg    <= cfg_data;
                CFG_PAUSE:     pause_reg     <= cfg_data;
                default:       ;
            endcase
        end
    end

    // Breathing window sums, refreshed every cycle from the timing registers.
    always_ff @(posedge clk)
    begin
        ramp_sum_reg <= 17'(inhale_reg) + 17'(exhale_reg);
        cycle_reg    <= 18'(inhale_reg) + 18'(exhale_reg) + 18'(pause_reg);
    end

    // Capture the time stamp and the elapsed time when a transaction is accepted.
    always_ff @(posedge clk)
    begin
        if (cmd.load) begin
            now_reg     <= now_ms;
            elapsed_reg <= now_ms - last_change_reg;
        end
    end

    // Breathing phase: restart past the full cycle, then rising ramp, falling ramp or pause.
    assign restart      = (elapsed_reg > 32'(cycle_reg));
    assign breath_e     = restart ? 32'd0 : elapsed_reg;
    assign below_inhale = (breath_e < 32'(inhale_reg));
    assign below_ramps  = (breath_e < 32'(ramp_sum_reg));
    assign exhale_left  = ramp_sum_reg - breath_e[16:0];

    // Pattern decision for the current mode.
    always_comb
    begin
        br_eval = brightness_reg;
        touch   = 1'b0;
        do_div  = 1'b0;
        div_num = '0;
        div_den = inhale_reg;
        unique case (mode_reg)
            MODE_OFF: begin
                br_eval = '0;
            end
            MODE_ON: begin
                br_eval = PCT_FULL;
            end
            MODE_SLOW: begin
                if (brightness_reg == PCT_FULL) begin
                    if (elapsed_reg > 32'(slow_on_reg)) begin
                        br_eval = '0;
                        touch   = 1'b1;
                    end
                end else if (elapsed_reg > 32'(slow_off_reg)) begin
                    br_eval = PCT_FULL;
                    touch   = 1'b1;
                end
            end
            MODE_FAST: begin
                if (elapsed_reg >= 32'(fast_half_reg)) begin
                    br_eval = (brightness_reg == '0) ? PCT_FULL : 7'd0;
                    touch   = 1'b1;
                end
            end
            MODE_BREATHE: begin
                touch  = restart;
                do_div = below_ramps;
                if (below_inhale) begin
                    div_num = breath_e[15:0];
                    div_den = inhale_reg;
                end else begin
                    div_num = exhale_left[15:0];
                    div_den = exhale_reg;
                end
            end
            default: ;
        endcase
    end

    // Evaluation results held for the finish step.
    always_ff @(posedge clk)
    begin
        if (cmd.eval) begin
            br_pend_reg  <= br_eval;
            div_used_reg <= do_div;
        end
    end

    lpg_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.eval & do_div),
        .num      (div_num),
        .den      (div_den),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    // Final brightness: ramp quotient, breathing floor, full-scale clamp.
    assign br_pre   = div_used_reg ? div_quo : br_pend_reg;
    assign br_floor = ((mode_reg == MODE_BREATHE) && (br_pre < BREATH_FLOOR)) ?
                      BREATH_FLOOR : br_pre;
    assign br_fin   = (br_floor > PCT_FULL) ? PCT_FULL : br_floor;

    // Brightness state; a mode change clears it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            brightness_reg <= '0;
        end else if (cfg_we && (cfg_index == CFG_MODE) && (cfg_data[2:0] != mode_reg)) begin
            brightness_reg <= '0;
        end else if (cmd.finish) begin
            brightness_reg <= br_fin;
        end
    end

    // Time of the last pattern change.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            last_change_reg <= '0;
        end else if (cmd.eval && touch) begin
            last_change_reg <= now_reg;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (cmd.finish) begin
            pwm_reg <= PWM_TOP - pwm_curve(br_fin);
            pct_reg <= br_fin;
        end
    end

    assign sts.div_busy   = div_busy;
    assign pwm_level      = pwm_reg;
    assign brightness_pct = pct_reg;

    // Checks.
    `LPG_ASSERT_IMP(a_br_range, clk, rst_n, 1'b1, brightness_reg <= PCT_FULL)
    `LPG_ASSERT_NXT(a_div_starts, clk, rst_n, cmd.eval && do_div, div_busy)
    `LPG_ASSERT_NXT(a_breath_floor, clk, rst_n,
        cmd.finish && (mode_reg == MODE_BREATHE) && !cfg_we,
        brightness_reg >= BREATH_FLOOR)

endmodule

[design/lpg_ctrl.sv]
// Controller of the LED pattern generator: sequences load, evaluate, divide and
// finish, and owns the output valid flag. Depends on lpg_pkg.
`include "assert_macros.svh"
module lpg_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  lpg_pkg::lpg_sts_t sts,
    output lpg_pkg::lpg_cmd_t cmd
);
    import lpg_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_WAIT,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    // The output register can take a new result when empty or being drained.
    assign out_free = !out_valid_reg || out_ready;

    // Commands to the datapath.
    assign cmd.load   = (state_reg == S_IDLE) && in_valid;
    assign cmd.eval   = (state_reg == S_EVAL);
    assign cmd.finish = (state_reg == S_FINISH) && out_free;

    // Next state and output flag.
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                state_next = S_WAIT;
            end
            S_WAIT: begin
                if (!sts.div_busy) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // Checks.
    `LPG_ASSERT_NXT(a_accept_evals, clk, rst_n, in_valid && in_ready, state_reg == S_EVAL)
    `LPG_ASSERT_NXT(a_wait_done, clk, rst_n,
        (state_reg == S_WAIT) && !sts.div_busy, state_reg == S_FINISH)
    `LPG_ASSERT_NXT(a_finish_valid, clk, rst_n, cmd.finish, out_valid_reg && in_ready)

endmodule

[design/led_pattern_generator_unit.sv]
// LED pattern generator: an accepted input transaction passes the evaluate, wait and
// finish states before its result is valid; when a breathing ramp needs its percentage,
// the wait state holds for the 7-step restoring divider, one quotient bit a cycle. A new
// input is taken only after the last has finished, and finish waits for a free output.
// A finished result waits in the output register while the next transaction is accepted.
// Reset (rst_n, asynchronous, active low) restores register defaults, clears brightness.
module led_pattern_generator_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] now_ms,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [9:0]  pwm_level,
    output logic [6:0]  brightness_pct
);
    import lpg_pkg::*;

    lpg_cmd_t cmd;
    lpg_sts_t sts;

    // Sequencing.
    lpg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Pattern state and arithmetic.
    lpg_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .now_ms         (now_ms),
        .cmd            (cmd),
        .sts            (sts),
        .pwm_level      (pwm_level),
        .brightness_pct (brightness_pct)
    );

endmodule

[sim/led_pattern_checker.sv]
// Checker for the LED pattern generator: watches the register port and both channels,
// predicts each brightness and PWM level on its own and compares field by field.
// Depends on lpg_pkg for mode codes, register indexes and reset values.
module led_pattern_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [31:0] now_ms,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [9:0]  pwm_level,
    input  logic [6:0]  brightness_pct,
    output int          in_flight,
    output int          fail_count
);
    import lpg_pkg::*;

    typedef struct packed {
        logic [9:0] pwm;
        logic [6:0] pct;
    } led_level_t;

    // Shadow copy of the registers and of the pattern state.
    logic [2:0]  mode_q;
    logic [15:0] slow_on_q;
    logic [15:0] slow_off_q;
    logic [15:0] fast_half_q;
    logic [15:0] inhale_q;
    logic [15:0] exhale_q;
    logic [15:0] pause_q;
    logic [6:0]  pct_q;
    logic [31:0] mark_ms;

    // Levels still owed by the block, oldest first.
    led_level_t level_fifo[$];
    logic [9:0] duty_table [0:100];
    int         mismatches = 0;

    assign fail_count = mismatches;

    // Active-low duty for percent p: 1023 - (floor(2^(p/10)) - 1), where the floor is
    // the largest integer k with k^10 <= 2^p, found by binary search.
    function automatic logic [9:0] duty_for(input int unsigned p);
        logic [127:0] lim;
        logic [127:0] acc;
        int unsigned  lo;
        int unsigned  hi;
        int unsigned  mid;
        lim = 128'd1 << p;
        lo = 1;
        hi = 1024;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) / 2;
            acc = 128'd1;
            repeat (10) acc = acc * mid;
            if (acc <= lim)
                lo = mid;
            else
                hi = mid - 1;
        end
        return 10'(1023 - (lo - 1));
    endfunction

    initial
    begin
        for (int p = 0; p <= 100; p++)
            duty_table[p] = duty_for(p);
    end

    // Percent of a ramp, rounded half up.
    function automatic logic [6:0] ramp_pct(input logic [31:0] num, input logic [31:0] den);
        logic [63:0] q;
        q = (64'd200 * num + den) / (64'd2 * den);
        return q[6:0];
    endfunction

    // A register write; a mode change clears the brightness.
    function automatic void apply_write(input logic [2:0] idx, input logic [15:0] val);
        case (idx)
            CFG_MODE:
            begin
                if (val[2:0] != mode_q)
                begin
                    mode_q = val[2:0];
                    pct_q = '0;
                end
            end
            CFG_SLOW_ON:   slow_on_q = val;
            CFG_SLOW_OFF:  slow_off_q = val;
            CFG_FAST_HALF: fast_half_q = val;
            CFG_INHALE:    inhale_q = val;
            CFG_EXHALE:    exhale_q = val;
            CFG_PAUSE:     pause_q = val;
            default: ;
        endcase
    endfunction

    // One update at time t: advance the pattern and return the level it shows.
    function automatic led_level_t step_pattern(input logic [31:0] t);
        logic [31:0] gap_ms;
        logic [31:0] span;
        logic [31:0] ramp_end;
        led_level_t  lvl;
        gap_ms = t - mark_ms;
        case (mode_q)
            MODE_OFF: pct_q = '0;
            MODE_ON:  pct_q = PCT_FULL;
            MODE_SLOW:
            begin
                if (pct_q == PCT_FULL)
                begin
                    if (gap_ms > slow_on_q)
                    begin
                        pct_q = '0;
                        mark_ms = t;
                    end
                end
                else if (gap_ms > slow_off_q)
                begin
                    pct_q = PCT_FULL;
                    mark_ms = t;
                end
            end
            MODE_FAST:
            begin
                if (gap_ms >= fast_half_q)
                begin
                    pct_q = (pct_q == 0) ? PCT_FULL : 7'd0;
                    mark_ms = t;
                end
            end
            MODE_BREATHE:
            begin
                // A breath restarts once the whole cycle has gone by.
                span = inhale_q + exhale_q + pause_q;
                if (gap_ms > span)
                begin
                    mark_ms = t;
                    gap_ms = '0;
                end
                ramp_end = inhale_q + exhale_q;
                if (gap_ms < inhale_q)
                    pct_q = ramp_pct(gap_ms, inhale_q);
                else if (gap_ms < ramp_end)
                    pct_q = ramp_pct(exhale_q - (gap_ms - inhale_q), exhale_q);
                if (pct_q < BREATH_FLOOR)
                    pct_q = BREATH_FLOOR;
            end
            default: ;
        endcase
        if (pct_q > PCT_FULL)
            pct_q = PCT_FULL;
        lvl.pwm = duty_table[pct_q];
        lvl.pct = pct_q;
        return lvl;
    endfunction

    // Track register writes and transactions on both channels.
    always @(posedge clk or negedge rst_n)
    begin
        int         taken;
        int         given;
        led_level_t want;
        if (!rst_n)
        begin
            mode_q      = MODE_OFF;
            slow_on_q   = RST_SLOW_ON;
            slow_off_q  = RST_SLOW_OFF;
            fast_half_q = RST_FAST_HALF;
            inhale_q    = RST_INHALE;
            exhale_q    = RST_EXHALE;
            pause_q     = RST_PAUSE;
            pct_q       = '0;
            mark_ms     = '0;
            level_fifo.delete();
            in_flight <= 0;
        end
        else
        begin
            taken = 0;
            given = 0;
            if (cfg_we)
                apply_write(cfg_index, cfg_data);
            if (in_valid && in_ready)
            begin
                taken = 1;
                level_fifo.push_back(step_pattern(now_ms));
            end
            if (out_valid && out_ready)
            begin
                given = 1;
                if (level_fifo.size() == 0)
                begin
                    $error("Output transaction with no update pending: pwm_level %0d, brightness_pct %0d",
                           pwm_level, brightness_pct);
                    mismatches++;
                end
                else
                begin
                    want = level_fifo.pop_front();
                    if (pwm_level !== want.pwm)
                    begin
                        $error("pwm_level: expected %0d, actual %0d", want.pwm, pwm_level);
                        mismatches++;
                    end
                    if (brightness_pct !== want.pct)
                    begin
                        $error("brightness_pct: expected %0d, actual %0d", want.pct, brightness_pct);
                        mismatches++;
                    end
                end
            end
            in_flight <= in_flight + taken - given;
        end
    end

endmodule

[sim/testbench.sv]
// Top of the LED pattern generator testbench: clock, reset, register writes and update
// transactions with random idling on both channels, and the final verdict.
// Depends on lpg_pkg, led_pattern_generator_unit and led_pattern_checker.
module testbench;
    import lpg_pkg::*;

    localparam logic [2:0] CFG_SPARE    = 3'd7;
    localparam logic [2:0] MODE_SPARE   = 3'd5;
    localparam logic [2:0] MODE_LAST    = 3'd7;
    localparam int         PHASES       = 30;
    localparam int         PHASE_ITEMS  = 55;
    localparam int         HOLD_PHASE   = 7;
    localparam int         HOLD_CYCLES  = 300;
    localparam int         DRAIN_CYCLES = 30;
    localparam int         CYCLE_LIMIT  = 500000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [31:0] now_ms = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [9:0]  pwm_level;
    logic [6:0]  brightness_pct;

    int          in_flight;
    int          fail_count;
    int          cycle_count = 0;
    bit          no_idle = 1'b0;
    bit          hold_req = 1'b0;

    led_pattern_generator_unit u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .now_ms         (now_ms),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .pwm_level      (pwm_level),
        .brightness_pct (brightness_pct)
    );

    led_pattern_checker u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .now_ms         (now_ms),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .pwm_level      (pwm_level),
        .brightness_pct (brightness_pct),
        .in_flight      (in_flight),
        .fail_count     (fail_count)
    );

    always #4 clk = ~clk;

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[led_pattern_generator_unit] ERROR");
            $finish;
        end
    end

    // Stop offering updates and wait until every transaction has come back.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (in_flight != 0) @(posedge clk);
    endtask

    // Register write, only once the block is idle.
    task automatic set_reg(input logic [2:0] idx, input logic [15:0] val);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Offer one update transaction after a random gap and wait for its acceptance.
    task automatic send(input logic [31:0] t);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        now_ms   <= t;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // Timing register values: mostly short, with the extremes and full-range values.
    function automatic logic [15:0] pick_ms();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 16'd0;
        if (r == 1)
            return 16'hFFFF;
        if (r < 4)
            return 16'($urandom);
        return 16'($urandom_range(1, 400));
    endfunction

    // Result side: random stalls, one long hold-off on request.
    initial
    begin : sink
        int unsigned stall;
        bit          held;
        held = 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (hold_req && !held)
            begin
                stall = HOLD_CYCLES;
                held = 1'b1;
            end
            else
            begin
                stall = no_idle ? 0 : $urandom_range(0, 10);
            end
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    // Update side: directed cases, then random phases of settings and updates.
    initial
    begin : stimulus
        logic [31:0] t_ms;
        logic [2:0]  mode_sel;
        logic [15:0] son;
        logic [15:0] soff;
        logic [15:0] fh;
        logic [15:0] inh;
        logic [15:0] exh;
        logic [15:0] pau;
        int unsigned span;
        int unsigned step_max;
        int unsigned r;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Power-on settings with the LED off, at both ends of the time range.
        send(32'd0);
        send(32'hFFFF_FFFF);

        // An index past the register list is ignored; mode bits above the field drop.
        set_reg(CFG_SPARE, 16'hFFFF);
        set_reg(CFG_MODE, {13'h1FFF, MODE_ON});
        send(32'd5);

        // Unused mode: cleared by the mode change, then held as it is.
        set_reg(CFG_MODE, {13'd0, MODE_SPARE});
        send(32'd6);

        // Slow blink at both thresholds, with the same mode written again while lit.
        set_reg(CFG_MODE, {13'd0, MODE_SLOW});
        send(32'd2000);
        send(32'd2001);
        set_reg(CFG_MODE, {13'd0, MODE_SLOW});
        send(32'd2051);
        send(32'd2052);

        // Fast toggle, then a zero half period that toggles on every update.
        set_reg(CFG_MODE, {13'd0, MODE_FAST});
        send(32'd2100);
        send(32'd2152);
        send(32'd2252);
        set_reg(CFG_FAST_HALF, 16'd0);
        send(32'd2252);

        // Breathing on default timing: floor, both ramps, peak, pause and restart.
        set_reg(CFG_MODE, {13'd0, MODE_BREATHE});
        send(32'd2352);
        send(32'd3252);
        send(32'd4252);
        send(32'd5502);
        send(32'd7952);
        send(32'd7953);

        // Zero-length ramps and pause: every update restarts at the floor.
        set_reg(CFG_INHALE, 16'd0);
        set_reg(CFG_EXHALE, 16'd0);
        set_reg(CFG_PAUSE, 16'd0);
        send(32'd8000);

        t_ms = 32'd8000;
        for (int ph = 0; ph < PHASES; ph++)
        begin
            r = $urandom_range(0, 19);
            if (r == 0)
                mode_sel = MODE_OFF;
            else if (r == 1)
                mode_sel = MODE_ON;
            else if (r < 4)
                mode_sel = 3'($urandom_range(MODE_SPARE, MODE_LAST));
            else if (r < 9)
                mode_sel = MODE_SLOW;
            else if (r < 14)
                mode_sel = MODE_FAST;
            else
                mode_sel = MODE_BREATHE;
            son  = pick_ms();
            soff = pick_ms();
            fh   = pick_ms();
            inh  = pick_ms();
            exh  = pick_ms();
            pau  = pick_ms();

            // The extreme settings come first.
            if (ph == 0)
            begin
                mode_sel = MODE_BREATHE;
                son = 16'hFFFF; soff = 16'hFFFF; fh = 16'hFFFF;
                inh = 16'hFFFF; exh = 16'hFFFF; pau = 16'hFFFF;
            end
            else if (ph == 1)
            begin
                mode_sel = MODE_SLOW;
                son = '0; soff = '0; fh = '0;
                inh = '0; exh = '0; pau = '0;
            end

            set_reg(CFG_MODE, {13'($urandom), mode_sel});
            set_reg(CFG_SLOW_ON, son);
            set_reg(CFG_SLOW_OFF, soff);
            set_reg(CFG_FAST_HALF, fh);
            set_reg(CFG_INHALE, inh);
            set_reg(CFG_EXHALE, exh);
            set_reg(CFG_PAUSE, pau);

            // Time steps scale with the pattern's own period.
            case (mode_sel)
                MODE_SLOW:    span = son + soff;
                MODE_FAST:    span = fh;
                MODE_BREATHE: span = inh + exh + pau;
                default:      span = 1000;
            endcase
            step_max = span / 4 + 1;

            if (ph % 6 == 3)
                t_ms = 32'hFFFF_FFFF - $urandom_range(0, step_max * 4);
            no_idle = ($urandom_range(0, 3) == 0);
            if (ph == HOLD_PHASE)
            begin
                no_idle = 1'b0;
                hold_req = 1'b1;
            end

            // Mostly forward time, with rare jumps and steps backward.
            repeat (PHASE_ITEMS)
            begin
                r = $urandom_range(0, 19);
                if (r == 0)
                    t_ms = $urandom;
                else if (r == 1)
                    t_ms = t_ms - $urandom_range(0, step_max);
                else
                    t_ms = t_ms + $urandom_range(0, step_max);
                send(t_ms);
            end
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("[led_pattern_generator_unit] OK");
        else
            $display("[led_pattern_generator_unit] ERROR");
        $finish;
    end

endmodule

[sim.f]
+incdir+design
design/lpg_pkg.sv
design/lpg_divider.sv
design/lpg_datapath.sv
design/lpg_ctrl.sv
design/led_pattern_generator_unit.sv
sim/led_pattern_checker.sv
sim/testbench.sv
